// ----- rtl/su16s_pkg.sv -----
// Shared constants and control types for the sorted 16-bit set.
package su16s_pkg;

	// Store size and derived widths.
	localparam int CAPACITY = 4096;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 16;
	localparam int COUNT_W  = 13;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	// Operation codes of an input beat.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// Source of the store read address.
	typedef enum logic [1:0] {
		A_LAST,
		A_MID,
		A_SHIFT
	} addr_sel_t;

	// Kind of store write.
	typedef enum logic [1:0] {
		W_NONE,
		W_APPEND,
		W_SHIFT,
		W_PUT
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		addr_sel_t addr_sel;
		wr_sel_t   wr_sel;
		logic      mid_capture;
		logic      srch_step;
		logic      shift_init;
		logic      finish;
		logic      res_found;
		logic      res_added;
		logic      res_full;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic count_zero;
		logic full;
		logic gt_rd;
		logic eq_rd;
		logic srch_done;
		logic shift_last;
		logic out_busy;
	} status_t;

endpackage

// ----- rtl/su16s_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module su16s_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/su16s_dp.sv -----
// Datapath of the sorted set: operand registers, search bounds, shift index, store and result register.
module su16s_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  su16s_pkg::cmd_t              cmd,
	output su16s_pkg::status_t           status,
	input  logic                         operation,
	input  logic [su16s_pkg::VAL_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic                         added,
	output logic                         full_error,
	output logic [su16s_pkg::COUNT_W-1:0] count
);
	import su16s_pkg::*;

	logic             op_q;
	logic [VAL_W-1:0] value_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] mid_q;
	logic [CNT_W-1:0] sh_q;
	logic [CNT_W-1:0] count_q;

	logic               out_valid_q;
	logic               found_q;
	logic               added_q;
	logic               full_q;
	logic [COUNT_W-1:0] count_out_q;

	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  last_idx;
	logic [CNT_W-1:0]  shift_src;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [VAL_W-1:0]  wdata;
	logic [VAL_W-1:0]  rdata;
	logic              we;

	// Midpoint of the open search window and the fixed address sources.
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign last_idx  = count_q - CNT_W'(1);
	assign shift_src = sh_q - CNT_W'(1);

	// Read address selection.
	always_comb begin
		case (cmd.addr_sel)
			A_LAST:  raddr = last_idx[ADDR_W-1:0];
			A_MID:   raddr = mid[ADDR_W-1:0];
			A_SHIFT: raddr = shift_src[ADDR_W-1:0];
			default: raddr = last_idx[ADDR_W-1:0];
		endcase
	end

	// Write address and data selection.
	always_comb begin
		we    = 1'b1;
		waddr = count_q[ADDR_W-1:0];
		wdata = value_q;
		case (cmd.wr_sel)
			W_APPEND: begin
				waddr = count_q[ADDR_W-1:0];
				wdata = value_q;
			end
			W_SHIFT: begin
				waddr = sh_q[ADDR_W-1:0];
				wdata = rdata;
			end
			W_PUT: begin
				waddr = lo_q[ADDR_W-1:0];
				wdata = value_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	su16s_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Operand capture, binary search bounds and shift index.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			value_q <= value;
			lo_q    <= '0;
			hi_q    <= count_q;
		end
		if (cmd.mid_capture) begin
			mid_q <= mid;
		end
		if (cmd.srch_step) begin
			if (value_q < rdata) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_q + CNT_W'(1);
			end
		end
		if (cmd.shift_init) begin
			sh_q <= count_q;
		end else if (cmd.wr_sel == W_SHIFT) begin
			sh_q <= shift_src;
		end
	end

	// Number of values held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_sel == W_APPEND || cmd.wr_sel == W_PUT) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register: result beat.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q     <= cmd.res_found;
			added_q     <= cmd.res_added;
			full_q      <= cmd.res_full;
			count_out_q <= count_q[COUNT_W-1:0];
		end
	end

	// Status towards the controller.
	always_comb begin
		status.is_query   = (op_q == OP_QUERY);
		status.count_zero = (count_q == '0);
		status.full       = (count_q == CAP_COUNT);
		status.gt_rd      = (value_q > rdata);
		status.eq_rd      = (value_q == rdata);
		status.srch_done  = (lo_q >= hi_q);
		status.shift_last = (shift_src == lo_q);
		status.out_busy   = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign added      = added_q;
	assign full_error = full_q;
	assign count      = count_out_q;

endmodule

// ----- rtl/su16s_ctrl.sv -----
// Controller of the sorted set: sequences append check, binary search, shift and result.
module su16s_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  su16s_pkg::status_t status,
	output su16s_pkg::cmd_t    cmd
);
	import su16s_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_LAST_CMP,
		S_APPEND,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_DONE
	} state_t;

	state_t state_q;
	logic   res_found_q;
	logic   res_added_q;
	logic   res_full_q;

	// State and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_found_q <= 1'b0;
			res_added_q <= 1'b0;
			res_full_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_found_q <= 1'b0;
						res_added_q <= 1'b0;
						res_full_q  <= 1'b0;
						state_q     <= S_START;
					end
				end
				S_START: begin
					if (status.is_query) begin
						state_q <= S_SRCH_RD;
					end else if (status.count_zero) begin
						state_q <= S_APPEND;
					end else begin
						state_q <= S_LAST_CMP;
					end
				end
				S_LAST_CMP: begin
					if (!status.gt_rd) begin
						state_q <= S_SRCH_RD;
					end else if (status.full) begin
						res_full_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					res_added_q <= 1'b1;
					state_q     <= S_DONE;
				end
				S_SRCH_RD: begin
					if (!status.srch_done) begin
						state_q <= S_SRCH_CMP;
					end else if (status.is_query) begin
						state_q <= S_DONE;
					end else if (status.full) begin
						res_full_q <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_SRCH_CMP: begin
					if (status.eq_rd) begin
						res_found_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					if (status.shift_last) begin
						state_q <= S_PUT;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_PUT: begin
					res_added_q <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!status.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands decoded from the state.
	always_comb begin
		cmd             = '0;
		cmd.addr_sel    = A_LAST;
		cmd.wr_sel      = W_NONE;
		cmd.res_found   = res_found_q;
		cmd.res_added   = res_added_q;
		cmd.res_full    = res_full_q;
		case (state_q)
			S_IDLE:     cmd.load = in_valid;
			S_START:    cmd.addr_sel = A_LAST;
			S_SRCH_RD: begin
				cmd.addr_sel    = A_MID;
				cmd.mid_capture = 1'b1;
				cmd.shift_init  = status.srch_done;
			end
			S_SRCH_CMP: cmd.srch_step = !status.eq_rd;
			S_SHIFT_RD: cmd.addr_sel = A_SHIFT;
			S_SHIFT_WR: cmd.wr_sel = W_SHIFT;
			S_APPEND:   cmd.wr_sel = W_APPEND;
			S_PUT:      cmd.wr_sel = W_PUT;
			S_DONE:     cmd.finish = !status.out_busy;
			default:    cmd.load = 1'b0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ----- rtl/sorted_u16_set.sv -----
// Sorted set of up to 4096 distinct 16-bit values in one single-port-write, registered-read RAM.
// Each input beat inserts or queries a value and yields exactly one result beat. An insert into an
// empty store appends at once; otherwise it first reads the largest entry, and a larger value is
// appended, or refused with full_error when the store is full. For a value that is not larger, and
// for every query, a binary search runs, each probe setting the address and then comparing on the
// registered read data. An insert of a missing value then moves every entry above its position up
// one place, reading and then writing each entry, and then places the value; a full store refuses
// it with full_error instead. A new beat is taken as soon as the previous result sits in the output
// register, even while that result still waits for out_ready. The store needs no clearing after
// reset; only entries below the held count are ever read.
module sorted_u16_set (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [su16s_pkg::VAL_W-1:0]   value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic                          added,
	output logic                          full_error,
	output logic [su16s_pkg::COUNT_W-1:0] count
);
	import su16s_pkg::*;

	cmd_t    cmd;
	status_t status;

	su16s_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	su16s_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.operation (operation),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.added     (added),
		.full_error(full_error),
		.count     (count)
	);

endmodule

// ----- verif/su16s_checker.sv -----
// Checker for the sorted 16-bit set: predicts each result beat and compares it field by field.
`timescale 1ns / 1ps

module su16s_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          operation,
	input  logic [su16s_pkg::VAL_W-1:0]   value,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          found,
	input  logic                          added,
	input  logic                          full_error,
	input  logic [su16s_pkg::COUNT_W-1:0] count,
	output int                            errors,
	output int                            pending
);
	import su16s_pkg::*;

	// One predicted result beat.
	typedef struct packed {
		logic               found;
		logic               added;
		logic               full_error;
		logic [COUNT_W-1:0] count;
	} set_result_t;

	// Shadow copy of the set, ascending and distinct, and the results still owed.
	logic [VAL_W-1:0] shadow_vals [CAPACITY];
	int               shadow_size;
	set_result_t      owed_results [$];
	set_result_t      oldest;

	// Binary search over the held entries; slot gets the index or the insert position.
	function automatic bit find_slot(input logic [VAL_W-1:0] v, output int slot);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = shadow_size;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (shadow_vals[mid] == v) begin
				slot = mid;
				return 1'b1;
			end else if (shadow_vals[mid] < v) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		slot = lo;
		return 1'b0;
	endfunction

	// Applies one input beat to the shadow set and returns the result it should produce.
	function automatic set_result_t apply_beat(input logic op, input logic [VAL_W-1:0] v);
		set_result_t r;
		int          slot;
		int          i;
		bit          hit;
		r   = '0;
		hit = find_slot(v, slot);
		if (op == OP_QUERY) begin
			r.found = hit;
		end else if (hit) begin
			r.found = 1'b1;
		end else if (shadow_size >= CAPACITY) begin
			r.full_error = 1'b1;
		end else begin
			// Entries at and above the slot move up one place; an append moves nothing.
			for (i = shadow_size; i > slot; i--)
				shadow_vals[i] = shadow_vals[i - 1];
			shadow_vals[slot] = v;
			shadow_size++;
			r.added = 1'b1;
		end
		r.count = COUNT_W'(shadow_size);
		return r;
	endfunction

	// Result beats are checked before the input beat of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_size = 0;
			owed_results.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					$error("result beat with nothing expected: %s %0d %0d %0d %0d",
						"found/added/full_error/count", found, added, full_error, count);
					errors++;
				end else begin
					oldest = owed_results.pop_front();
					if (found !== oldest.found) begin
						$error("found: expected %0d, actual %0d", oldest.found, found);
						errors++;
					end
					if (added !== oldest.added) begin
						$error("added: expected %0d, actual %0d", oldest.added, added);
						errors++;
					end
					if (full_error !== oldest.full_error) begin
						$error("full_error: expected %0d, actual %0d",
							oldest.full_error, full_error);
						errors++;
					end
					if (count !== oldest.count) begin
						$error("count: expected %0d, actual %0d", oldest.count, count);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				owed_results.push_back(apply_beat(operation, value));
			pending = owed_results.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// Top of the sorted 16-bit set testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb;
	import su16s_pkg::*;

	localparam int RANDOM_BEATS = 1000;
	localparam int APPEND_BEATS = 120;
	localparam int CYCLE_LIMIT  = 8_000_000;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               operation  = OP_INSERT;
	logic [VAL_W-1:0]   value      = '0;
	logic               out_ready  = 1'b0;
	logic               in_ready;
	logic               out_valid;
	logic               found;
	logic               added;
	logic               full_error;
	logic [COUNT_W-1:0] count;

	int                 errors;
	int                 pending;
	int                 cycles;
	bit                 quiet;
	logic [VAL_W-1:0]   sent_values [$];

	sorted_u16_set uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.added      (added),
		.full_error (full_error),
		.count      (count)
	);

	su16s_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.added      (added),
		.full_error (full_error),
		.count      (count),
		.errors     (errors),
		.pending    (pending)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls with a probability of about 12 percent, except during the quiet stretch.
	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 12);
	end

	// Offers one input beat from a falling edge and returns at the falling edge after it is taken.
	task automatic send_beat(input logic op, input logic [VAL_W-1:0] v);
		int gap;
		if (!quiet && $urandom_range(99) < 12) begin
			gap = $urandom_range(4, 1);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		value     <= v;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		if (op == OP_INSERT)
			sent_values.push_back(v);
	endtask

	// Picks a value that has been offered for insertion before, or any value if none has.
	function automatic logic [VAL_W-1:0] earlier_value();
		if (sent_values.size() == 0)
			return VAL_W'($urandom_range(16'hFFFF));
		return sent_values[$urandom_range(sent_values.size() - 1)];
	endfunction

	initial begin
		int i;
		int roll;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats: empty store, appends, placement at the bottom, repeats and misses.
		// Inserts stay below 16'hC000 so that the append run can go above them.
		send_beat(OP_QUERY, 16'h0000);
		send_beat(OP_QUERY, 16'hFFFF);
		send_beat(OP_INSERT, 16'h4000);
		send_beat(OP_INSERT, 16'h7FFF);
		send_beat(OP_INSERT, 16'h0000);
		send_beat(OP_INSERT, 16'h4000);
		send_beat(OP_INSERT, 16'h7FFF);
		send_beat(OP_INSERT, 16'h0000);
		send_beat(OP_INSERT, 16'h5555);
		send_beat(OP_INSERT, 16'hAAAA);
		send_beat(OP_INSERT, 16'h2AAA);
		send_beat(OP_QUERY, 16'h5555);
		send_beat(OP_QUERY, 16'hAAAA);
		send_beat(OP_QUERY, 16'h0000);
		send_beat(OP_QUERY, 16'hFFFF);
		send_beat(OP_QUERY, 16'h4001);
		send_beat(OP_INSERT, 16'h0001);
		send_beat(OP_INSERT, 16'hAAA9);

		// Random mix of new inserts, repeated inserts and queries, with one stretch of no idling.
		for (i = 0; i < RANDOM_BEATS; i++) begin
			quiet = (i >= 400 && i < 600);
			roll  = $urandom_range(99);
			if (roll < 45)
				send_beat(OP_INSERT, VAL_W'($urandom_range(16'hBFFF)));
			else if (roll < 60)
				send_beat(OP_INSERT, earlier_value());
			else if (roll < 85)
				send_beat(OP_QUERY, earlier_value());
			else
				send_beat(OP_QUERY, VAL_W'($urandom_range(16'hFFFF)));
		end
		quiet = 1'b0;

		// A run of ascending appends above every value inserted so far.
		for (i = 0; i < APPEND_BEATS; i++)
			send_beat(OP_INSERT, VAL_W'(16'hC000 + 2 * i));

		// Top value, a placement inside the appended run and a repeated insert.
		send_beat(OP_INSERT, 16'hFFFF);
		send_beat(OP_QUERY, 16'hFFFF);
		send_beat(OP_INSERT, 16'hC001);
		send_beat(OP_INSERT, 16'hC000);
		in_valid <= 1'b0;

		// Drain the outstanding results, then allow a short tail for stray beats.
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
